FILE: rtl/lbr_pkg.sv
package lbr_pkg;

    // Generator and field widths
    localparam int STATE_BITS = 48;
    localparam int DRAW_BITS  = 31;
    localparam int HALF_BITS  = STATE_BITS / 2;
    localparam int CNT_BITS   = 5;

    // APB configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 64;

    // Register index, taken from paddr[3]
    localparam logic REG_SEED = 1'b0;

    // Generator constants
    localparam logic [STATE_BITS-1:0] LCG_MULT   = 48'h0005_DEEC_E66D;
    localparam logic [STATE_BITS-1:0] LCG_INC    = 48'h0000_0000_000B;
    localparam logic [STATE_BITS-1:0] SEED_RESET = 48'h0048_4F55_5345;
    localparam logic [STATE_BITS-1:0] STATE_RESET = SEED_RESET ^ LCG_MULT;
    localparam logic [HALF_BITS-1:0]  MULT_LO    = LCG_MULT[HALF_BITS-1:0];
    localparam logic [HALF_BITS-1:0]  MULT_HI    = LCG_MULT[STATE_BITS-1:HALF_BITS];

    // Partial product phases of one generator step
    localparam logic [1:0] PH_LO  = 2'd0;
    localparam logic [1:0] PH_MID = 2'd1;
    localparam logic [1:0] PH_HI  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic       take_bound;
        logic       lcg_en;
        logic [1:0] lcg_phase;
        logic       div_init;
        logic       div_step;
        logic       load_res;
        logic       load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pow2;
        logic div_last;
        logic reject;
    } sts_t;

endpackage

FILE: rtl/lbr_ifs.sv
interface lbr_req_if;
    logic                       valid;
    logic                       ready;
    logic [lbr_pkg::DRAW_BITS-1:0] bound;

    modport source (output valid, output bound, input ready);
    modport sink   (input valid, input bound, output ready);
endinterface

interface lbr_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [lbr_pkg::DRAW_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

FILE: rtl/lbr_dp.sv
module lbr_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          seed_load,
    input  logic [lbr_pkg::STATE_BITS-1:0] seed_value,
    input  logic [lbr_pkg::DRAW_BITS-1:0]  bound,
    input  lbr_pkg::cmd_t                 cmd,
    output lbr_pkg::sts_t                 sts,
    output logic [lbr_pkg::DRAW_BITS-1:0]  value
);

    localparam int SB = lbr_pkg::STATE_BITS;
    localparam int DB = lbr_pkg::DRAW_BITS;
    localparam int HB = lbr_pkg::HALF_BITS;

    logic [SB-1:0]                 state_reg, state_next;
    logic [SB-1:0]                 acc_reg, acc_next;
    logic [DB-1:0]                 bound_reg;
    logic [DB-1:0]                 rem_reg, rem_next;
    logic [DB-1:0]                 dvd_reg, dvd_next;
    logic [lbr_pkg::CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [DB-1:0]                 res_reg, res_next;
    logic [DB-1:0]                 value_reg;

    logic [HB-1:0]   mul_a;
    logic [HB-1:0]   mul_k;
    logic [SB-1:0]   prod;
    logic [HB-1:0]   upper_sum;
    logic [DB-1:0]   draw;
    logic [DB-1:0]   draw_new;
    logic [2*DB-1:0] scale;
    logic [DB+1:0]   trial;
    logic [DB:0]     slack;
    logic [DB-1:0]   neg_bound;

    // Select operands of the shared 24x24 multiplier
    always_comb
    begin
        case (cmd.lcg_phase)
            lbr_pkg::PH_LO:
            begin
                mul_a = state_reg[HB-1:0];
                mul_k = lbr_pkg::MULT_LO;
            end
            lbr_pkg::PH_MID:
            begin
                mul_a = state_reg[SB-1:HB];
                mul_k = lbr_pkg::MULT_LO;
            end
            lbr_pkg::PH_HI:
            begin
                mul_a = state_reg[HB-1:0];
                mul_k = lbr_pkg::MULT_HI;
            end
            default:
            begin
                mul_a = '0;
                mul_k = '0;
            end
        endcase
    end

    assign prod      = mul_a * mul_k;
    assign upper_sum = acc_reg[SB-1:HB] + prod[HB-1:0];
    assign draw      = state_reg[SB-1:SB-DB];
    assign draw_new  = {upper_sum, acc_reg[HB-1:SB-DB]};

    // Accumulate partial products, commit the new state in the last phase
    always_comb
    begin
        acc_next   = acc_reg;
        state_next = state_reg;
        if (seed_load)
        begin
            state_next = seed_value ^ lbr_pkg::LCG_MULT;
        end
        else if (cmd.lcg_en)
        begin
            case (cmd.lcg_phase)
                lbr_pkg::PH_LO:
                begin
                    acc_next = prod + lbr_pkg::LCG_INC;
                end
                lbr_pkg::PH_MID:
                begin
                    acc_next = {upper_sum, acc_reg[HB-1:0]};
                end
                lbr_pkg::PH_HI:
                begin
                    state_next = {upper_sum, acc_reg[HB-1:0]};
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    // Restoring remainder, one dividend bit per cycle
    assign trial = {1'b0, rem_reg, dvd_reg[DB-1]} - {2'b00, bound_reg};

    always_comb
    begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        cnt_next = cnt_reg;
        if (cmd.div_init)
        begin
            rem_next = '0;
            dvd_next = draw_new;
            cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            rem_next = trial[DB+1] ? {rem_reg[DB-2:0], dvd_reg[DB-1]} : trial[DB-1:0];
            dvd_next = {dvd_reg[DB-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // Power-of-two bound scales the draw
    assign scale = bound_reg * draw;

    // Result select
    always_comb
    begin
        res_next = res_reg;
        if (cmd.load_res)
        begin
            res_next = sts.pow2 ? scale[2*DB-1:DB] : rem_reg;
        end
    end

    // Status
    assign neg_bound    = ~bound_reg + 1'b1;
    assign slack        = {1'b0, draw} - {1'b0, rem_reg} + {1'b0, bound_reg} - 1'b1;
    assign sts.pow2     = (bound_reg & neg_bound) == bound_reg;
    assign sts.div_last = cnt_reg == lbr_pkg::CNT_BITS'(DB - 1);
    assign sts.reject   = slack[DB];

    // Generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbr_pkg::STATE_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
        if (cmd.take_bound)
        begin
            bound_reg <= bound;
        end
        if (cmd.load_out)
        begin
            value_reg <= res_reg;
        end
    end

    assign value = value_reg;

endmodule

FILE: rtl/lbr_ctrl.sv
module lbr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  lbr_pkg::sts_t sts,
    output lbr_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LCG0   = 3'd1;
    localparam logic [2:0] S_LCG1   = 3'd2;
    localparam logic [2:0] S_LCG2   = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_CHECK  = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = out_valid_reg;

    // Sequence one request: draw, scale (power-of-two bound) or reduce and check (reject redraws), finish
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take_bound = req_valid;
                if (req_valid)
                begin
                    state_next = S_LCG0;
                end
            end
            S_LCG0:
            begin
                cmd.lcg_en    = 1'b1;
                cmd.lcg_phase = lbr_pkg::PH_LO;
                state_next    = S_LCG1;
            end
            S_LCG1:
            begin
                cmd.lcg_en    = 1'b1;
                cmd.lcg_phase = lbr_pkg::PH_MID;
                state_next    = S_LCG2;
            end
            S_LCG2:
            begin
                cmd.lcg_en    = 1'b1;
                cmd.lcg_phase = lbr_pkg::PH_HI;
                cmd.div_init  = 1'b1;
                state_next    = sts.pow2 ? S_MUL : S_DIV;
            end
            S_MUL:
            begin
                cmd.load_res = 1'b1;
                state_next   = S_FINISH;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.reject)
                begin
                    state_next = S_LCG0;
                end
                else
                begin
                    cmd.load_res = 1'b1;
                    state_next   = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output slot: fill on finish, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> state_reg == S_LCG0)
        else $error("accepted request did not start a draw");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || rsp_ready))
        else $error("output slot overwritten while full");

    a_mul_only_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL |-> sts.pow2)
        else $error("scale path used for a bound that is not a power of two");

    a_check_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> $past(state_reg == S_DIV && sts.div_last))
        else $error("rejection test reached before the remainder finished");

endmodule

FILE: rtl/lcg48_bounded_random_unit.sv
// A request is accepted, then the generator steps through phases LO, MID and HI; for a
// bound that is not a power of two the one-bit divider forms the remainder, the draw is
// tested and a rejected draw returns to the generator. Power-of-two bounds scale instead.
// Throughput: one request in flight; a new request is taken while the result waits.
// Reset: asynchronous active-low; seed returns to 0x484F555345, generator state
// to seed XOR 0x5DEECE66D, no request pending and no result valid.
module lcg48_bounded_random_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lbr_pkg::APB_AW-1:0]  paddr,
    input  logic [lbr_pkg::APB_DW-1:0]  pwdata,
    output logic [lbr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    lbr_req_if.sink                     req,
    lbr_rsp_if.source                   rsp
);

    logic [lbr_pkg::STATE_BITS-1:0] seed_reg, seed_next;
    logic                           seed_load;
    lbr_pkg::cmd_t                  cmd;
    lbr_pkg::sts_t                  sts;

    // Decode register writes
    assign pready    = 1'b1;
    assign seed_load = psel && penable && pwrite && (paddr[3] == lbr_pkg::REG_SEED);
    assign seed_next = seed_load ? pwdata[lbr_pkg::STATE_BITS-1:0] : seed_reg;

    // Register readback
    always_comb
    begin
        prdata = '0;
        if (paddr[3] == lbr_pkg::REG_SEED)
        begin
            prdata = lbr_pkg::APB_DW'(seed_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= lbr_pkg::SEED_RESET;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    lbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lbr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_load  (seed_load),
        .seed_value (pwdata[lbr_pkg::STATE_BITS-1:0]),
        .bound      (req.bound),
        .cmd        (cmd),
        .sts        (sts),
        .value      (rsp.value)
    );

endmodule

FILE: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 1_000_000;
    localparam int  DRAIN_CYCLES = 40;
    localparam logic [lbr_pkg::APB_AW-1:0] ADDR_SEED  = 4'h0;
    localparam logic [lbr_pkg::APB_AW-1:0] ADDR_STRAY = 4'h8;
    localparam logic [lbr_pkg::STATE_BITS-1:0] STATE_MASK = {lbr_pkg::STATE_BITS{1'b1}};

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [lbr_pkg::APB_AW-1:0] paddr;
    logic [lbr_pkg::APB_DW-1:0] pwdata;
    logic [lbr_pkg::APB_DW-1:0] prdata;
    logic pready;

    lbr_req_if req_ch ();
    lbr_rsp_if rsp_ch ();

    lcg48_bounded_random_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // Generator mirror and pending traffic
    logic [lbr_pkg::STATE_BITS-1:0] seed_mirror;
    logic [lbr_pkg::STATE_BITS-1:0] gen_state;
    logic [lbr_pkg::DRAW_BITS-1:0]  bounds_pending[$];
    logic [lbr_pkg::DRAW_BITS-1:0]  values_due[$];
    int unsigned issued;
    int unsigned accepted;
    int unsigned errors;
    int unsigned cycles;
    bit steady;
    bit req_took;

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Step the 48-bit generator and return its top 31 bits
    function automatic logic [63:0] lcg_draw();
        gen_state = gen_state * lbr_pkg::LCG_MULT + lbr_pkg::LCG_INC;
        return {33'b0, gen_state[lbr_pkg::STATE_BITS-1:lbr_pkg::STATE_BITS-lbr_pkg::DRAW_BITS]};
    endfunction

    // Bounded draw, power-of-two scaling or modulo with rejection
    function automatic logic [lbr_pkg::DRAW_BITS-1:0] next_bounded_value(
        logic [lbr_pkg::DRAW_BITS-1:0] b);
        logic [31:0] b32;
        logic [31:0] neg;
        logic [63:0] b64;
        logic [63:0] d;
        logic [63:0] r;
        b32 = {1'b0, b};
        neg = ~b32 + 32'd1;
        b64 = {33'b0, b};
        if ((b32 & neg) == b32)
        begin
            d = lcg_draw();
            r = (b64 * d) >> lbr_pkg::DRAW_BITS;
        end
        else
        begin
            d = lcg_draw();
            r = d % b64;
            while (d - r + (b64 - 64'd1) >= 64'h8000_0000)
            begin
                d = lcg_draw();
                r = d % b64;
            end
        end
        return r[lbr_pkg::DRAW_BITS-1:0];
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        if (errors <= 50)
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    endtask

    // Monitor: check results, then record accepted requests
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (values_due.size() == 0)
                    report_mismatch("value with no request waiting", rsp_ch.value, 0);
                else
                begin
                    logic [lbr_pkg::DRAW_BITS-1:0] want;
                    want = values_due.pop_front();
                    if (rsp_ch.value !== want)
                        report_mismatch("value", rsp_ch.value, want);
                end
            end
            req_took = req_ch.valid && req_ch.ready;
            if (req_took)
            begin
                values_due.push_back(next_bounded_value(req_ch.bound));
                accepted++;
            end
        end
        else
            req_took = 1'b0;
    end

    // Timeout
    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Driver: hold an unaccepted request, else issue the next one or idle
    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (req_ch.valid && !req_took)
        begin
            // hold
        end
        else if (bounds_pending.size() > 0 && (steady || $urandom_range(99) >= 25))
        begin
            req_ch.valid <= 1'b1;
            req_ch.bound <= bounds_pending.pop_front();
        end
        else
            req_ch.valid <= 1'b0;
    end

    // Result side stalls
    always @(negedge clk)
    begin
        rsp_ch.ready <= rst_n && (steady || $urandom_range(99) >= 25);
    end

    // Register write: setup phase, then access phase
    task automatic apb_write(logic [lbr_pkg::APB_AW-1:0] addr,
                             logic [lbr_pkg::APB_DW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr[3] == lbr_pkg::REG_SEED)
        begin
            seed_mirror = data[lbr_pkg::STATE_BITS-1:0] & STATE_MASK;
            gen_state   = seed_mirror ^ lbr_pkg::LCG_MULT;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [lbr_pkg::DRAW_BITS-1:0] pick_bound();
        case ($urandom_range(9))
            0: return 31'd1 << $urandom_range(30);
            1: return 31'($urandom_range(16, 1));
            2: return 31'($urandom_range(1000, 1));
            3, 4, 5: return 31'($urandom());
            6: return 31'h4000_0000 + 31'($urandom_range(32'h2000_0000, 1));
            7: return 31'h7FFF_FFFF - 31'($urandom_range(255));
            8: return 31'($urandom_range(32'h0001_0000));
            default: return ($urandom_range(4) == 0) ? 31'd0
                                                     : 31'($urandom() >> $urandom_range(31));
        endcase
    endfunction

    function automatic void queue_random(int n);
        repeat (n)
        begin
            bounds_pending.push_back(pick_bound());
            issued++;
        end
    endfunction

    // Pause until every request of the phase has its result
    task automatic wait_idle();
        do
            @(negedge clk);
        while (bounds_pending.size() != 0 || accepted != issued || values_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Stimulus
    initial
    begin
        logic [lbr_pkg::DRAW_BITS-1:0] corner[$];
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_ch.valid = 1'b0;
        req_ch.bound = '0;
        rsp_ch.ready = 1'b0;
        steady       = 1'b0;
        seed_mirror  = lbr_pkg::SEED_RESET;
        gen_state    = lbr_pkg::SEED_RESET ^ lbr_pkg::LCG_MULT;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Reset seed: field extremes, bound of zero, powers of two, rejection-heavy bounds
        corner = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd5, 31'd6, 31'd7, 31'h0001_0000,
                   31'h4000_0000, 31'h4000_0001, 31'h4000_0003, 31'h7FFF_FFFF,
                   31'h7FFF_FFFE, 31'h5555_5555, 31'h2AAA_AAAA, 31'd1000000007,
                   31'h3FFF_FFFF, 31'h6000_0001};
        foreach (corner[i])
        begin
            bounds_pending.push_back(corner[i]);
            issued++;
        end
        queue_random(80);
        wait_idle();

        // Zero seed
        apb_write(ADDR_SEED, 64'd0);
        queue_random(200);
        wait_idle();

        // All-ones seed, no stalls on either side
        apb_write(ADDR_SEED, {lbr_pkg::APB_DW{1'b1}});
        steady = 1'b1;
        queue_random(250);
        wait_idle();
        steady = 1'b0;

        // Seed equal to the multiplier gives a zero state; stray address is ignored
        apb_write(ADDR_SEED, {16'hA5A5, lbr_pkg::LCG_MULT});
        apb_write(ADDR_STRAY, {$urandom(), $urandom()});
        queue_random(200);
        wait_idle();

        // Random seed
        apb_write(ADDR_SEED, {$urandom(), $urandom()});
        queue_random(350);
        wait_idle();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/lbr_pkg.sv
rtl/lbr_ifs.sv
rtl/lbr_dp.sv
rtl/lbr_ctrl.sv
rtl/lcg48_bounded_random_unit.sv
bench/tb.sv
